>>> sv/aesr_pkg.sv
package aesr_pkg;

  localparam int unsigned BlockW = 128;

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;

  localparam logic FuncFwd = 1'b0;
  localparam logic FuncInv = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;

  localparam byte_t [0:255] FwdBox = '{
    8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,8'd48,8'd1,8'd103,8'd43,
    8'd254,8'd215,8'd171,8'd118,8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,
    8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,8'd183,8'd253,8'd147,8'd38,
    8'd54,8'd63,8'd247,8'd204,8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
    8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,8'd7,8'd18,8'd128,8'd226,
    8'd235,8'd39,8'd178,8'd117,8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,
    8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,8'd83,8'd209,8'd0,8'd237,
    8'd32,8'd252,8'd177,8'd91,8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
    8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,8'd69,8'd249,8'd2,8'd127,
    8'd80,8'd60,8'd159,8'd168,8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,
    8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,8'd205,8'd12,8'd19,8'd236,
    8'd95,8'd151,8'd68,8'd23,8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
    8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,8'd70,8'd238,8'd184,8'd20,
    8'd222,8'd94,8'd11,8'd219,8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,
    8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,8'd231,8'd200,8'd55,8'd109,
    8'd141,8'd213,8'd78,8'd169,8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
    8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,8'd232,8'd221,8'd116,8'd31,
    8'd75,8'd189,8'd139,8'd138,8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,
    8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,8'd225,8'd248,8'd152,8'd17,
    8'd105,8'd217,8'd142,8'd148,8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
    8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,8'd65,8'd153,8'd45,8'd15,
    8'd176,8'd84,8'd187,8'd22
  };

  localparam byte_t [0:255] InvBox = '{
    8'd82,8'd9,8'd106,8'd213,8'd48,8'd54,8'd165,8'd56,8'd191,8'd64,8'd163,8'd158,
    8'd129,8'd243,8'd215,8'd251,8'd124,8'd227,8'd57,8'd130,8'd155,8'd47,8'd255,8'd135,
    8'd52,8'd142,8'd67,8'd68,8'd196,8'd222,8'd233,8'd203,8'd84,8'd123,8'd148,8'd50,
    8'd166,8'd194,8'd35,8'd61,8'd238,8'd76,8'd149,8'd11,8'd66,8'd250,8'd195,8'd78,
    8'd8,8'd46,8'd161,8'd102,8'd40,8'd217,8'd36,8'd178,8'd118,8'd91,8'd162,8'd73,
    8'd109,8'd139,8'd209,8'd37,8'd114,8'd248,8'd246,8'd100,8'd134,8'd104,8'd152,8'd22,
    8'd212,8'd164,8'd92,8'd204,8'd93,8'd101,8'd182,8'd146,8'd108,8'd112,8'd72,8'd80,
    8'd253,8'd237,8'd185,8'd218,8'd94,8'd21,8'd70,8'd87,8'd167,8'd141,8'd157,8'd132,
    8'd144,8'd216,8'd171,8'd0,8'd140,8'd188,8'd211,8'd10,8'd247,8'd228,8'd88,8'd5,
    8'd184,8'd179,8'd69,8'd6,8'd208,8'd44,8'd30,8'd143,8'd202,8'd63,8'd15,8'd2,
    8'd193,8'd175,8'd189,8'd3,8'd1,8'd19,8'd138,8'd107,8'd58,8'd145,8'd17,8'd65,
    8'd79,8'd103,8'd220,8'd234,8'd151,8'd242,8'd207,8'd206,8'd240,8'd180,8'd230,8'd115,
    8'd150,8'd172,8'd116,8'd34,8'd231,8'd173,8'd53,8'd133,8'd226,8'd249,8'd55,8'd232,
    8'd28,8'd117,8'd223,8'd110,8'd71,8'd241,8'd26,8'd113,8'd29,8'd41,8'd197,8'd137,
    8'd111,8'd183,8'd98,8'd14,8'd170,8'd24,8'd190,8'd27,8'd252,8'd86,8'd62,8'd75,
    8'd198,8'd210,8'd121,8'd32,8'd154,8'd219,8'd192,8'd254,8'd120,8'd205,8'd90,8'd244,
    8'd31,8'd221,8'd168,8'd51,8'd136,8'd7,8'd199,8'd49,8'd177,8'd18,8'd16,8'd89,
    8'd39,8'd128,8'd236,8'd95,8'd96,8'd81,8'd127,8'd169,8'd25,8'd181,8'd74,8'd13,
    8'd45,8'd229,8'd122,8'd159,8'd147,8'd201,8'd156,8'd239,8'd160,8'd224,8'd59,8'd77,
    8'd174,8'd42,8'd245,8'd176,8'd200,8'd235,8'd187,8'd60,8'd131,8'd83,8'd153,8'd97,
    8'd23,8'd43,8'd4,8'd126,8'd186,8'd119,8'd214,8'd38,8'd225,8'd105,8'd20,8'd99,
    8'd85,8'd33,8'd12,8'd125
  };

  // Multiply by x in GF(2^8) with the AES polynomial.
  function automatic byte_t xtime(byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

endpackage

>>> sv/aesr_core.sv
// One forward or inverse AES round on a 16-byte state, purely combinational.
// Byte k of the block (byte 0 in the top bits) is state row k%4, column k/4.
module aesr_core (
  input  logic                         func_i,
  input  logic [aesr_pkg::BlockW-1:0]  block_i,
  input  logic [aesr_pkg::BlockW-1:0]  key_i,
  output logic [aesr_pkg::BlockW-1:0]  result_o
);

  aesr_pkg::state_t st_in, st_fs, st_fm, st_im, st_out;
  aesr_pkg::byte_t  a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
  logic [aesr_pkg::BlockW-1:0] add_in;

  // st[4c+r] holds block byte 4c+r; block byte k sits at bits 127-8k.
  assign add_in = (func_i == aesr_pkg::FuncInv) ? (block_i ^ key_i) : block_i;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      st_in[k] = add_in[aesr_pkg::BlockW-1-8*k -: 8];
    end
    // Forward: SubBytes then ShiftRows (row r rotated left by r).
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        st_fs[4*c+r] = aesr_pkg::FwdBox[st_in[4*((c+r)%4)+r]];
      end
    end
  end

  // Column mixing; each column independent.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      a0 = st_fs[4*c]; a1 = st_fs[4*c+1]; a2 = st_fs[4*c+2]; a3 = st_fs[4*c+3];
      x0 = aesr_pkg::xtime(a0); x1 = aesr_pkg::xtime(a1);
      x2 = aesr_pkg::xtime(a2); x3 = aesr_pkg::xtime(a3);
      st_fm[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      st_fm[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      st_fm[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      st_fm[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;

      // Inverse: multiples 2,4,8 of each byte build 0E, 0B, 0D, 09.
      a0 = st_in[4*c]; a1 = st_in[4*c+1]; a2 = st_in[4*c+2]; a3 = st_in[4*c+3];
      x0 = aesr_pkg::xtime(a0); x1 = aesr_pkg::xtime(a1);
      x2 = aesr_pkg::xtime(a2); x3 = aesr_pkg::xtime(a3);
      y0 = aesr_pkg::xtime(x0); y1 = aesr_pkg::xtime(x1);
      y2 = aesr_pkg::xtime(x2); y3 = aesr_pkg::xtime(x3);
      z0 = aesr_pkg::xtime(y0); z1 = aesr_pkg::xtime(y1);
      z2 = aesr_pkg::xtime(y2); z3 = aesr_pkg::xtime(y3);
      st_im[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
      st_im[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
      st_im[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
      st_im[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
    end
  end

  // Inverse: InvShiftRows (row r rotated right by r) then InvSubBytes.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (func_i == aesr_pkg::FuncInv) begin
          st_out[4*c+r] = aesr_pkg::InvBox[st_im[4*((c+4-r)%4)+r]];
        end else begin
          st_out[4*c+r] = st_fm[4*c+r];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      result_o[aesr_pkg::BlockW-1-8*k -: 8] = st_out[k];
    end
    if (func_i == aesr_pkg::FuncFwd) begin
      result_o = result_o ^ key_i;
    end
  end

endmodule

>>> sv/aes_single_round.sv
// An accepted block is registered as a valid result in the following cycle;
// one block per cycle unless stalled. The round is a single combinational pass
// through the S-box tables and column mixing into the output register.
// While a result waits on a stalled output, the input is held off.
// Reset clears the output valid flag and both round key registers to zero.
module aes_single_round (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // block_high [63:0], block_low [127:64]
  input  logic         s_axis_tuser_i,  // func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o   // result_high [63:0], result_low [127:64]
);

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] res_d, res_q;
  logic         valid_q;
  logic         accept;

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      if ({1'b0, cfg_idx_i} == aesr_pkg::CfgKeyHigh) key_hi_q <= cfg_wdata_i;
      if ({1'b0, cfg_idx_i} == aesr_pkg::CfgKeyLow)  key_lo_q <= cfg_wdata_i;
    end
  end

  aesr_core u_core (
    .func_i   (s_axis_tuser_i),
    .block_i  ({s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]}),
    .key_i    ({key_hi_q, key_lo_q}),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {res_q[63:0], res_q[127:64]};

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted block produced no result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("empty output stage refused input");

endmodule
